// ===== design/bsba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsba_pkg
// Shared types, codes and constants for the batched scatter bitwise atomic
// block.
// ----------------------------------------------------------------------------
package bsba_pkg;

    localparam int MEM_DEPTH_DEF  = 4096;
    localparam int FAST_DEPTH_DEF = 1024;

    localparam int WORD_W      = 64;
    localparam int HALF_W      = 32;
    localparam int OFFSET_W    = 16;
    localparam int FAST_SIZE_W = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int EPOCH_W     = 8;

    localparam logic [1:0] OPC_ATOMIC = 2'd0;
    localparam logic [1:0] OPC_WRITE  = 2'd1;
    localparam logic [1:0] OPC_READ   = 2'd2;

    localparam logic [1:0] AOP_OR  = 2'd0;
    localparam logic [1:0] AOP_AND = 2'd1;
    localparam logic [1:0] AOP_XOR = 2'd2;

    localparam logic [1:0] STS_FAST   = 2'd0;
    localparam logic [1:0] STS_DIRECT = 2'd1;
    localparam logic [1:0] STS_MASKED = 2'd2;
    localparam logic [1:0] STS_RANGE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ATOMIC_OP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_WORDS = 2'd2;

    localparam logic [1:0]             ATOMIC_OP_RST  = AOP_OR;
    localparam logic [FAST_SIZE_W-1:0] FAST_SIZE_RST  = 11'd1024;
    localparam logic                   WIDE_WORDS_RST = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } bsba_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic clear;
    } bsba_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic out_free;
        logic eob;
        logic epoch_last;
    } bsba_sts_t;

endpackage

// ===== design/bsba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsba_ctrl
// Controller: tag clear sweep, transaction accept and execute sequencing.
// ----------------------------------------------------------------------------
module bsba_ctrl
    import bsba_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bsba_sts_t sts,
    output bsba_cmd_t cmd
);

    bsba_state_t state_reg;
    bsba_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    state_next = (sts.eob && sts.epoch_last) ? ST_CLEAR : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        cmd.load  = 1'b0;
        cmd.exec  = 1'b0;
        cmd.clear = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EXEC: begin
                cmd.exec = sts.out_free;
            end
            default: begin
                cmd.clear = 1'b0;
            end
        endcase
    end

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !cmd.load && !cmd.exec)
        else $error("accept or execute during tag clear");

    a_exec_follows_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> $past(cmd.load) || $past(state_reg == ST_EXEC))
        else $error("execute without a loaded transaction");

    a_wrap_enters_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && sts.eob && sts.epoch_last |=> cmd.clear)
        else $error("epoch wrap did not start a clear sweep");

endmodule

// ===== design/bsba_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsba_datapath
// Datapath: config registers, target memory, snapshot memory with epoch
// tags, update logic and output register.
// ----------------------------------------------------------------------------
module bsba_datapath
    import bsba_pkg::*;
#(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int FAST_DEPTH = FAST_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic [1:0]                 s_opcode,
    input  logic signed [OFFSET_W-1:0] s_elem_offset,
    input  logic [WORD_W-1:0]          s_elem_value,
    input  logic                       s_lane_enable,
    input  logic                       s_end_of_batch,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [WORD_W-1:0]          m_old_value,
    output logic [1:0]                 m_status,
    input  bsba_cmd_t                  cmd,
    output bsba_sts_t                  sts
);

    localparam int MEM_AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int FAST_AW = (FAST_DEPTH > 1) ? $clog2(FAST_DEPTH) : 1;
    localparam int SNAP_W  = EPOCH_W + WORD_W;

    // config
    logic [1:0]             atomic_op_reg;
    logic [FAST_SIZE_W-1:0] fast_size_reg;
    logic                   wide_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atomic_op_reg <= ATOMIC_OP_RST;
            fast_size_reg <= FAST_SIZE_RST;
            wide_reg      <= WIDE_WORDS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ATOMIC_OP:  atomic_op_reg <= cfg_wr_data[1:0];
                CFG_FAST_SIZE:  fast_size_reg <= cfg_wr_data[FAST_SIZE_W-1:0];
                CFG_WIDE_WORDS: wide_reg      <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // captured transaction
    logic [1:0]          op_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic [WORD_W-1:0]   val_reg;
    logic                en_reg;
    logic                eob_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_opcode;
            off_reg <= $unsigned(s_elem_offset);
            val_reg <= s_elem_value;
            en_reg  <= s_lane_enable;
            eob_reg <= s_end_of_batch;
        end
    end

    // epoch and clear sweep
    logic [EPOCH_W-1:0] epoch_reg;
    logic [FAST_AW-1:0] clr_cnt_reg;
    logic               clr_done;
    logic               epoch_last;

    assign clr_done   = cmd.clear && (clr_cnt_reg == FAST_AW'(FAST_DEPTH - 1));
    assign epoch_last = (epoch_reg == {EPOCH_W{1'b1}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg   <= EPOCH_W'(1);
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_done ? '0 : clr_cnt_reg + FAST_AW'(1);
            end
            if (clr_done) begin
                epoch_reg <= EPOCH_W'(1);
            end else if (cmd.exec && eob_reg && !epoch_last) begin
                epoch_reg <= epoch_reg + EPOCH_W'(1);
            end
        end
    end

    // execute logic
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  mem_q;
    logic [SNAP_W-1:0]  snap_q;
    logic [WORD_W-1:0]  cur;
    logic [WORD_W-1:0]  valm;
    logic [WORD_W-1:0]  upd;
    logic               in_range;
    logic               fast;
    logic               touched;
    logic [WORD_W-1:0]  res;
    logic [1:0]         status;
    logic               mem_we;
    logic               snap_we;
    logic [WORD_W-1:0]  mem_wdata;
    logic [MEM_AW-1:0]  idx;
    logic [FAST_AW-1:0] fidx;

    assign mask    = wide_reg ? {WORD_W{1'b1}} : {{(WORD_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
    assign cur     = mem_q & mask;
    assign valm    = val_reg & mask;
    assign idx     = off_reg[MEM_AW-1:0];
    assign fidx    = off_reg[FAST_AW-1:0];
    assign in_range = !off_reg[OFFSET_W-1] &&
                      ({1'b0, off_reg} < (OFFSET_W+1)'(MEM_DEPTH));
    assign fast    = (off_reg < {{(OFFSET_W-FAST_SIZE_W){1'b0}}, fast_size_reg}) &&
                     ({1'b0, off_reg} < (OFFSET_W+1)'(FAST_DEPTH));
    assign touched = (snap_q[SNAP_W-1:WORD_W] == epoch_reg);

    always_comb begin
        case (atomic_op_reg)
            AOP_OR:  upd = cur | valm;
            AOP_AND: upd = cur & valm;
            AOP_XOR: upd = cur ^ valm;
            default: upd = cur;
        endcase
    end

    always_comb begin
        res       = '0;
        status    = STS_MASKED;
        mem_we    = 1'b0;
        snap_we   = 1'b0;
        mem_wdata = upd;
        case (op_reg)
            OPC_ATOMIC: begin
                if (!en_reg) begin
                    res = mask;
                end else if (!in_range) begin
                    status = STS_RANGE;
                end else if (fast) begin
                    res     = (touched ? snap_q[WORD_W-1:0] : cur) & mask;
                    status  = STS_FAST;
                    mem_we  = 1'b1;
                    snap_we = !touched;
                end else begin
                    res    = cur;
                    status = STS_DIRECT;
                    mem_we = 1'b1;
                end
            end
            OPC_WRITE: begin
                mem_wdata = valm;
                if (!in_range) begin
                    status = STS_RANGE;
                end else begin
                    res    = cur;
                    status = STS_DIRECT;
                    mem_we = 1'b1;
                end
            end
            OPC_READ: begin
                if (!in_range) begin
                    status = STS_RANGE;
                end else begin
                    res    = cur;
                    status = STS_DIRECT;
                end
            end
            default: begin
                res    = '0;
                status = STS_MASKED;
            end
        endcase
    end

    // memories
    logic [WORD_W-1:0] target_mem [MEM_DEPTH];
    logic [SNAP_W-1:0] snap_mem   [FAST_DEPTH];

    always_ff @(posedge aclk) begin
        if (cmd.exec && mem_we) begin
            target_mem[idx] <= mem_wdata;
        end
        if (cmd.load) begin
            mem_q <= target_mem[s_elem_offset[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            snap_mem[clr_cnt_reg] <= '0;
        end else if (cmd.exec && snap_we) begin
            snap_mem[fidx] <= {epoch_reg, cur};
        end
        if (cmd.load) begin
            snap_q <= snap_mem[s_elem_offset[FAST_AW-1:0]];
        end
    end

    // output register
    logic              m_valid_reg;
    logic [WORD_W-1:0] m_old_value_reg;
    logic [1:0]        m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_old_value_reg <= res;
            m_status_reg    <= status;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_old_value = m_old_value_reg;
    assign m_status    = m_status_reg;

    assign sts.clr_done   = clr_done;
    assign sts.out_free   = !m_valid_reg || m_ready;
    assign sts.eob        = eob_reg;
    assign sts.epoch_last = epoch_last;

    a_epoch_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != '0)
        else $error("epoch zero collides with cleared tags");

    a_snap_only_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && snap_we |-> status == STS_FAST)
        else $error("snapshot written outside fast region");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !m_valid_reg || m_ready)
        else $error("pending result overwritten");

endmodule

// ===== design/batched_scatter_bitwise_atomic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batched_scatter_bitwise_atomic
// Word memory with batched indexed OR/AND/XOR updates, snapshot results for
// the fast region, and direct write/read access.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction is captured in an accept/read state, then
//   executed and written in ST_EXEC once the result register is free; result
//   and status are registered. No new transaction is accepted until then.
// Reset: synchronous, active low; config registers take their reset values.
// A tag clear sweep over all FAST_DEPTH snapshot entries runs after reset and
//   after every 255th end-of-batch transaction; s_ready is low during the sweep.
// ----------------------------------------------------------------------------
module batched_scatter_bitwise_atomic
    import bsba_pkg::*;
#(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int FAST_DEPTH = FAST_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_opcode,
    input  logic signed [OFFSET_W-1:0] s_elem_offset,
    input  logic [WORD_W-1:0]          s_elem_value,
    input  logic                       s_lane_enable,
    input  logic                       s_end_of_batch,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [WORD_W-1:0]          m_old_value,
    output logic [1:0]                 m_status
);

    bsba_cmd_t cmd;
    bsba_sts_t sts;

    bsba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bsba_datapath #(
        .MEM_DEPTH  (MEM_DEPTH),
        .FAST_DEPTH (FAST_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_opcode       (s_opcode),
        .s_elem_offset  (s_elem_offset),
        .s_elem_value   (s_elem_value),
        .s_lane_enable  (s_lane_enable),
        .s_end_of_batch (s_end_of_batch),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_old_value    (m_old_value),
        .m_status       (m_status),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// ===== test/batched_scatter_bitwise_atomic_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batched_scatter_bitwise_atomic_tb
// Drives scatter OR/AND/XOR, direct write/read and malformed transactions
// into the word memory block under several register settings. A local model
// of the memory, batch snapshot and touched bits predicts each response the
// directed table leaves open; each is checked field by field in arrival order.
// Both handshake sides stall at random; a long response hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module batched_scatter_bitwise_atomic_tb;
    import bsba_pkg::*;

    localparam int          MEM_DEPTH   = MEM_DEPTH_DEF;
    localparam int          FAST_DEPTH  = FAST_DEPTH_DEF;
    localparam logic [1:0]  OPC_NONE    = 2'd3;
    localparam logic [1:0]  AOP_KEEP    = 2'd3;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PHASE_ITEMS = 210;
    localparam logic [63:0] ALL_ONES    = '1;

    typedef struct {
        logic [1:0]         opcode;
        logic signed [15:0] offset;
        logic [63:0]        value;
        logic               lane;
        logic               eob;
    } scatter_req_t;

    typedef struct {
        logic [63:0] old_value;
        logic [1:0]  status;
        bit          old_known;
    } scatter_rsp_t;

    typedef struct {
        logic [1:0]  opcode;
        int          offset;
        logic [63:0] value;
        logic        lane;
        logic        eob;
        bit          typed;
        logic [63:0] old_value;
        logic [1:0]  status;
    } directed_row_t;

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index      = '0;
    logic [CFG_DATA_W-1:0]      cfg_wr_data    = '0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_opcode       = '0;
    logic signed [OFFSET_W-1:0] s_elem_offset  = '0;
    logic [WORD_W-1:0]          s_elem_value   = '0;
    logic                       s_lane_enable  = 1'b0;
    logic                       s_end_of_batch = 1'b0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic [WORD_W-1:0]          m_old_value;
    logic [1:0]                 m_status;

    batched_scatter_bitwise_atomic uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_elem_offset (s_elem_offset),
        .s_elem_value  (s_elem_value),
        .s_lane_enable (s_lane_enable),
        .s_end_of_batch(s_end_of_batch),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_old_value   (m_old_value),
        .m_status      (m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // model state
    bit [63:0]           word_model     [MEM_DEPTH];
    bit [63:0]           snapshot_model [FAST_DEPTH];
    bit [MEM_DEPTH-1:0]  word_written   = '0;
    bit [FAST_DEPTH-1:0] touched_model  = '0;
    logic [1:0]          op_sel         = AOP_OR;
    int                  fast_size      = 1024;
    bit                  wide_sel       = 1'b1;

    scatter_rsp_t scatter_responses_due[$];
    int           live_addrs[$];
    int           hot_addrs[$];
    int           mismatches  = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           hold_req    = 0;
    int           hold_seen   = 0;
    int           hold_left   = 0;

    function automatic logic [63:0] combine_word(input logic [63:0] a, input logic [63:0] b);
        case (op_sel)
            AOP_OR:  return a | b;
            AOP_AND: return a & b;
            AOP_XOR: return a ^ b;
            default: return a;
        endcase
    endfunction

    function automatic scatter_rsp_t apply_scatter(input scatter_req_t req);
        scatter_rsp_t rsp;
        logic [63:0]  wmask;
        logic [63:0]  val;
        logic [63:0]  cur;
        int           off;
        int           lim;
        wmask = wide_sel ? ALL_ONES : 64'h0000_0000_FFFF_FFFF;
        val = req.value & wmask;
        off = req.offset;
        lim = (fast_size > FAST_DEPTH) ? FAST_DEPTH : fast_size;
        rsp.old_value = '0;
        rsp.status = STS_MASKED;
        rsp.old_known = 1'b1;
        if (req.opcode == OPC_NONE) begin
        end else if (req.opcode == OPC_ATOMIC && !req.lane) begin
            rsp.old_value = wmask;
        end else if (off < 0 || off >= MEM_DEPTH) begin
            rsp.status = STS_RANGE;
        end else begin
            cur = word_model[off] & wmask;
            if (req.opcode == OPC_WRITE) begin
                rsp.old_value = cur;
                rsp.old_known = word_written[off];
                rsp.status = STS_DIRECT;
                word_model[off] = val;
                word_written[off] = 1'b1;
            end else if (req.opcode == OPC_READ) begin
                rsp.old_value = cur;
                rsp.status = STS_DIRECT;
            end else if (off < lim) begin
                if (!touched_model[off]) begin
                    snapshot_model[off] = cur;
                    touched_model[off] = 1'b1;
                end
                rsp.old_value = snapshot_model[off] & wmask;
                rsp.status = STS_FAST;
                word_model[off] = combine_word(cur, val) & wmask;
            end else begin
                rsp.old_value = cur;
                rsp.status = STS_DIRECT;
                word_model[off] = combine_word(cur, val) & wmask;
            end
        end
        if (req.eob) begin
            touched_model = '0;
        end
        return rsp;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int pick_written();
        if (hot_addrs.size() != 0 && $urandom_range(0, 99) < 60) begin
            return hot_addrs[$urandom_range(0, hot_addrs.size() - 1)];
        end
        return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 50) begin
            $display("ERROR at %0t: %s got %h want %h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    task automatic send_req(input scatter_req_t req, input bit use_typed,
                            input scatter_rsp_t typed);
        scatter_rsp_t due;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= req.opcode;
        s_elem_offset <= req.offset;
        s_elem_value <= req.value;
        s_lane_enable <= req.lane;
        s_end_of_batch <= req.eob;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        due = apply_scatter(req);
        scatter_responses_due.push_back(use_typed ? typed : due);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (scatter_responses_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [1:0] aop, input int fast, input bit wide,
                             input int tx_pct, input int rx_pct, input bit with_hold);
        scatter_req_t req;
        scatter_rsp_t unused_rsp;
        int           bound_addrs[5];
        int           lim;
        int           sel;
        int           a;
        unused_rsp = '{64'd0, 2'd0, 1'b0};
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;

        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ATOMIC_OP;
        cfg_wr_data <= CFG_DATA_W'(aop);
        @(posedge aclk);
        op_sel = aop;
        cfg_index <= CFG_FAST_SIZE;
        cfg_wr_data <= CFG_DATA_W'(fast);
        @(posedge aclk);
        fast_size = fast;
        cfg_index <= CFG_WIDE_WORDS;
        cfg_wr_data <= CFG_DATA_W'(wide);
        @(posedge aclk);
        wide_sel = wide;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);

        // seed the words around the fast region boundary
        lim = (fast > FAST_DEPTH) ? FAST_DEPTH : fast;
        bound_addrs = '{0, 1, lim - 1, lim, lim + 1};
        hot_addrs.delete();
        foreach (bound_addrs[i]) begin
            a = bound_addrs[i];
            if (a >= 0 && a < MEM_DEPTH) begin
                hot_addrs.push_back(a);
                if (!word_written[a]) live_addrs.push_back(a);
                req = '{OPC_WRITE, 16'(a), rand_word(), 1'($urandom), 1'b0};
                send_req(req, 1'b0, unused_rsp);
            end
        end

        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (with_hold && n == PHASE_ITEMS / 2) begin
                hold_req <= hold_req + 1;
            end
            sel = $urandom_range(0, 99);
            req.value = rand_word();
            req.lane = 1'($urandom);
            req.eob = ($urandom_range(0, 99) < 12);
            req.offset = 16'($urandom);
            if (sel < 60) begin
                req.opcode = OPC_ATOMIC;
                req.lane = 1'b1;
                req.offset = 16'(pick_written());
            end else if (sel < 72) begin
                a = $urandom_range(0, MEM_DEPTH - 1);
                if (!word_written[a]) live_addrs.push_back(a);
                req.opcode = OPC_WRITE;
                req.offset = 16'(a);
            end else if (sel < 80) begin
                req.opcode = OPC_READ;
                req.offset = 16'(pick_written());
            end else if (sel < 88) begin
                req.opcode = OPC_ATOMIC;
                req.lane = 1'b0;
            end else if (sel < 96) begin
                req.opcode = 2'($urandom_range(0, 2));
                req.lane = 1'b1;
                if ($urandom_range(0, 1) != 0) begin
                    req.offset = {1'b1, 15'($urandom)};
                end else begin
                    req.offset = 16'($urandom_range(MEM_DEPTH, 32767));
                end
            end else begin
                req.opcode = OPC_NONE;
            end
            send_req(req, 1'b0, unused_rsp);
        end
        drain_results();
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : rsp_monitor
        scatter_rsp_t due;
        if (aresetn && m_valid && m_ready) begin
            if (scatter_responses_due.size() == 0) begin
                report_mismatch("response with none pending", m_old_value, '0);
            end else begin
                due = scatter_responses_due.pop_front();
                if (due.old_known && m_old_value !== due.old_value) begin
                    report_mismatch("old_value", m_old_value, due.old_value);
                end
                if (m_status !== due.status) begin
                    report_mismatch("status", 64'(m_status), 64'(due.status));
                end
            end
        end
    end

    directed_row_t directed_rows [22] = '{
        '{OPC_READ,   -1,     64'd0,                 1'b1, 1'b0, 1'b1, 64'd0,    STS_RANGE},
        '{OPC_ATOMIC, 4096,   ALL_ONES,              1'b1, 1'b0, 1'b1, 64'd0,    STS_RANGE},
        '{OPC_WRITE,  32767,  64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b1, 64'd0,  STS_RANGE},
        '{OPC_ATOMIC, -32768, 64'd0,                 1'b0, 1'b0, 1'b1, ALL_ONES, STS_MASKED},
        '{OPC_NONE,   5,      ALL_ONES,              1'b1, 1'b1, 1'b1, 64'd0,    STS_MASKED},
        '{OPC_WRITE,  0,      64'd0,                 1'b1, 1'b0, 1'b0, 64'd0,    STS_DIRECT},
        '{OPC_WRITE,  4095,   ALL_ONES,              1'b0, 1'b0, 1'b0, 64'd0,    STS_DIRECT},
        '{OPC_READ,   0,      ALL_ONES,              1'b1, 1'b0, 1'b1, 64'd0,    STS_DIRECT},
        '{OPC_READ,   4095,   64'd0,                 1'b0, 1'b0, 1'b1, ALL_ONES, STS_DIRECT},
        '{OPC_WRITE,  1023,   64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 1'b0, 64'd0,  STS_DIRECT},
        '{OPC_WRITE,  1024,   64'hF0,                1'b1, 1'b0, 1'b0, 64'd0,    STS_DIRECT},
        '{OPC_ATOMIC, 0,      64'h5,                 1'b1, 1'b0, 1'b1, 64'd0,    STS_FAST},
        '{OPC_ATOMIC, 0,      64'hA0,                1'b1, 1'b0, 1'b1, 64'd0,    STS_FAST},
        '{OPC_READ,   0,      64'd0,                 1'b1, 1'b0, 1'b1, 64'hA5,   STS_DIRECT},
        '{OPC_ATOMIC, 1023,   64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b1,
          64'h0123_4567_89AB_CDEF, STS_FAST},
        '{OPC_ATOMIC, 0,      64'h1,                 1'b1, 1'b0, 1'b1, 64'hA5,   STS_FAST},
        '{OPC_ATOMIC, 1024,   64'h0F,                1'b1, 1'b0, 1'b1, 64'hF0,   STS_DIRECT},
        '{OPC_ATOMIC, 4095,   64'd0,                 1'b1, 1'b0, 1'b1, ALL_ONES, STS_DIRECT},
        '{OPC_WRITE,  0,      64'h1234,              1'b0, 1'b0, 1'b1, 64'hA5,   STS_DIRECT},
        '{OPC_READ,   4095,   64'd0,                 1'b0, 1'b0, 1'b1, ALL_ONES, STS_DIRECT},
        '{OPC_ATOMIC, 0,      ALL_ONES,              1'b0, 1'b1, 1'b1, ALL_ONES, STS_MASKED},
        '{OPC_ATOMIC, 0,      64'hFF00,              1'b1, 1'b0, 1'b0, 64'd0,    STS_FAST}
    };

    initial begin
        scatter_req_t req;
        scatter_rsp_t typed;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 14;
        rx_idle_pct <= 76;

        live_addrs = '{0, 4095, 1023, 1024};
        foreach (directed_rows[i]) begin
            req = '{directed_rows[i].opcode, 16'(directed_rows[i].offset),
                    directed_rows[i].value, directed_rows[i].lane, directed_rows[i].eob};
            typed = '{directed_rows[i].old_value, directed_rows[i].status, 1'b1};
            send_req(req, directed_rows[i].typed, typed);
        end
        drain_results();

        run_phase(AOP_OR,   1024, 1'b1, 14, 76, 1'b1);
        run_phase(AOP_AND,  0,    1'b1, 14, 76, 1'b0);
        run_phase(AOP_XOR,  1,    1'b0, 14, 76, 1'b0);
        run_phase(AOP_XOR,  512,  1'b1, 76, 14, 1'b0);
        run_phase(AOP_KEEP, 1023, 1'b0, 76, 14, 1'b0);
        run_phase(AOP_AND,  37,   1'b0, 76, 14, 1'b0);
        run_phase(AOP_OR,   1024, 1'b0, 0,  0,  1'b1);
        run_phase(AOP_XOR,  1023, 1'b1, 0,  0,  1'b0);
        run_phase(AOP_AND,  700,  1'b1, 0,  0,  1'b0);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
design/bsba_pkg.sv
design/bsba_ctrl.sv
design/bsba_datapath.sv
design/batched_scatter_bitwise_atomic.sv
test/batched_scatter_bitwise_atomic_tb.sv
